// ===== sv/kfe_pkg.sv =====
`timescale 1ns / 1ps

package kfe_pkg;

  localparam int MAX_KEY_LEN_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int KEY_CHARS       = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW   = 3'd0,
    CFG_KEY_HIGH  = 3'd1,
    CFG_KEY_LEN   = 3'd2,
    CFG_OPEN      = 3'd3,
    CFG_CLOSE     = 3'd4,
    CFG_KEEP      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_OPEN  = 2'd1,
    PH_FIELD = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_BYTE      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [8*KEY_CHARS-1:0] key;
    logic [4:0]             key_length;
    logic [7:0]             open_char;
    logic [7:0]             close_char;
    logic                   keep_close;
  } cfg_t;

  // word passed from the front to the back
  typedef struct packed {
    status_t    kind;
    logic [7:0] data;
  } qword_t;

  function automatic logic [7:0] key_char(input logic [8*KEY_CHARS-1:0] key, input int i);
    logic [7:0] c;
    c = 8'd0;
    if (i >= 0 && i < KEY_CHARS) begin
      c = key[8*i +: 8];
    end
    return c;
  endfunction

endpackage

// ===== sv/kfe_front.sv =====
`timescale 1ns / 1ps

module kfe_front #(
  parameter int MAX_KEY_LEN = kfe_pkg::MAX_KEY_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kfe_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           push,
  output kfe_pkg::qword_t push_word
);
  import kfe_pkg::*;

  localparam int SEEN_W = $clog2(MAX_KEY_LEN + 1);

  logic [7:0]        win_r [MAX_KEY_LEN];
  logic [7:0]        win_nxt [MAX_KEY_LEN];
  logic [SEEN_W-1:0] seen_r, seen_nxt, seen_shift;
  phase_t            phase_r, phase_nxt, step_phase;
  logic [SEEN_W-1:0] eff_len;
  logic [5:0]        klen6;
  logic              key_hit;

  // key length: zero acts as one, clamp to 16 and to the window depth
  always_comb begin
    klen6 = {1'b0, cfg.key_length};
    if (klen6 == 6'd0) klen6 = 6'd1;
    if (klen6 > 6'(KEY_CHARS)) klen6 = 6'(KEY_CHARS);
    if (klen6 > 6'(MAX_KEY_LEN)) klen6 = 6'(MAX_KEY_LEN);
    eff_len = SEEN_W'(klen6);
  end

  always_comb begin
    win_nxt[0] = in_byte;
    for (int j = 1; j < MAX_KEY_LEN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
    seen_shift = (seen_r == SEEN_W'(MAX_KEY_LEN)) ? seen_r : seen_r + SEEN_W'(1);
  end

  // window position j (0 = newest) holds key character eff_len-1-j
  always_comb begin
    key_hit = (seen_shift >= eff_len);
    for (int j = 0; j < MAX_KEY_LEN; j++) begin
      if (j < int'(eff_len)) begin
        if (win_nxt[j] != key_char(cfg.key, int'(eff_len) - 1 - j)) key_hit = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    step_phase = phase_r;
    case (phase_r)
      PH_KEY:   if (key_hit) step_phase = PH_OPEN;
      PH_OPEN:  if (in_byte == cfg.open_char) step_phase = PH_FIELD;
      PH_FIELD: if (in_byte == cfg.close_char) step_phase = PH_DONE;
      PH_DONE:  step_phase = PH_DONE;
      default:  step_phase = PH_KEY;
    endcase
    phase_nxt = in_last ? PH_KEY : step_phase;
  end

  // outputs
  always_comb begin
    push           = 1'b0;
    push_word.kind = ST_BYTE;
    push_word.data = in_byte;
    case (phase_r)
      PH_FIELD: begin
        if (in_byte == cfg.close_char) begin
          push           = accept;
          push_word.kind = ST_COMPLETE;
        end else if (!in_last) begin
          push = accept;
        end
      end
      default: ;
    endcase
    if (in_last && step_phase != PH_DONE) begin
      push           = accept;
      push_word.kind = ST_NOT_FOUND;
      push_word.data = 8'd0;
    end
  end

  // window contents past seen_r are never compared, so they need no clearing
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      phase_r <= PH_KEY;
    end else if (accept) begin
      seen_r  <= in_last ? '0 : seen_shift;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== sv/kfe_queue.sv =====
`timescale 1ns / 1ps

module kfe_queue #(
  parameter int DEPTH = kfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kfe_pkg::qword_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output kfe_pkg::qword_t rdata
);
  import kfe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qword_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

// ===== sv/kfe_back.sv =====
`timescale 1ns / 1ps

module kfe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            keep_close,
  input  logic            q_valid,
  input  kfe_pkg::qword_t q_data,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic [1:0]      out_status
);
  import kfe_pkg::*;

  logic       full_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  status_t    status_r;
  logic       load;

  assign load  = q_valid && (!full_r || out_pop);
  assign q_pop = load;

  always_comb begin
    byte_nxt   = q_data.data;
    bvalid_nxt = 1'b0;
    case (q_data.kind)
      ST_BYTE:      bvalid_nxt = 1'b1;
      ST_COMPLETE:  bvalid_nxt = keep_close;
      ST_NOT_FOUND: byte_nxt = 8'd0;
      default:      byte_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (load) begin
      full_r <= 1'b1;
    end else if (out_pop) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      status_r <= q_data.kind;
    end
  end

  assign out_empty      = !full_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_status     = status_r;

endmodule

// ===== sv/keyed_field_extractor_top.sv =====
`timescale 1ns / 1ps

// Keyed field extractor: takes one message byte per cycle on in_push/in_full and,
// after the configured key and opening delimiter, returns the field bytes, then a
// complete word (closing byte, byte_valid = keep_close) or a not-found word when the
// message ends first; bytes already returned for a not-found field are to be dropped.
// One byte per cycle while in_full is low: the key compare and phase update finish in
// the cycle the byte is taken. A result word is written into the short queue at the
// edge its byte is taken and loads from the queue into the output register once that
// register is free or being popped; in_full rises only when that queue is full because
// out_pop is held low. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while no message is in flight, as the block does not enforce it.

module keyed_field_extractor_top #(
  parameter int MAX_KEY_LEN = kfe_pkg::MAX_KEY_LEN_DEF,
  parameter int QUEUE_DEPTH = kfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_end_of_message,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [kfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kfe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kfe_pkg::*;

  cfg_t   cfg_r;
  logic   accept;
  logic   f_push;
  qword_t f_word;
  logic   q_valid, q_pop;
  qword_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key        <= '0;
      cfg_r.key_length <= 5'd1;
      cfg_r.open_char  <= 8'd58;
      cfg_r.close_char <= 8'd44;
      cfg_r.keep_close <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  cfg_r.key[63:0]   <= cfg_data;
        CFG_KEY_HIGH: cfg_r.key[127:64] <= cfg_data;
        CFG_KEY_LEN:  cfg_r.key_length  <= cfg_data[4:0];
        CFG_OPEN:     cfg_r.open_char   <= cfg_data[7:0];
        CFG_CLOSE:    cfg_r.close_char  <= cfg_data[7:0];
        CFG_KEEP:     cfg_r.keep_close  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept = in_push && !in_full;

  kfe_front #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_end_of_message),
    .push      (f_push),
    .push_word (f_word)
  );

  kfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_word),
    .full  (in_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_data)
  );

  kfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .keep_close     (cfg_r.keep_close),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status)
  );

endmodule

// ===== sv/kfe_checker.sv =====
`timescale 1ns / 1ps

module kfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic [1:0] out_status
);
  import kfe_pkg::*;

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == ST_BYTE || out_status == ST_COMPLETE ||
                    out_status == ST_NOT_FOUND))
    else $error("undefined status code");

  a_byte_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_BYTE) |-> out_byte_valid)
    else $error("field byte word without byte_valid");

  a_miss_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_NOT_FOUND) |-> (!out_byte_valid && out_byte == 8'd0))
    else $error("not-found word carries data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) &&
                                  $stable(out_status) && $stable(out_byte_valid)))
    else $error("stalled result word changed");

endmodule

bind keyed_field_extractor_top kfe_checker u_kfe_checker (.*);

// ===== dv/keyed_field_extractor_top_tb.sv =====
`timescale 1ns / 1ps

module keyed_field_extractor_top_tb;
  import kfe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int ITEM_TARGET    = 1550;
  localparam int TAIL_CYCLES    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_t    st;
  } field_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eom;
    logic        typed;
    logic        has;
    field_word_t w;
  } dir_row_t;

  // reset config: key is the single byte 0x00, open ':', close ',', keep_close 0
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, ST_BYTE}},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, ST_BYTE}},
    '{8'h2C, 1'b0, 1'b1, 1'b1, '{8'h2C, 1'b0, ST_COMPLETE}},
    '{8'h78, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h2C, 1'b1, 1'b1, 1'b1, '{8'h2C, 1'b0, ST_COMPLETE}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h41, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, ST_NOT_FOUND}},
    '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, ST_NOT_FOUND}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, ST_NOT_FOUND}},
    '{8'h3A, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h2C, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h7F, 1'b1, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h3A, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}},
    '{8'h80, 1'b1, 1'b0, 1'b0, '{8'h00, 1'b0, ST_BYTE}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [7:0]            in_byte;
  logic                  in_end_of_message;
  logic                  out_empty;
  logic                  out_pop;
  logic [7:0]            out_byte;
  logic                  out_byte_valid;
  logic [1:0]            out_status;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // extractor copy: configuration and message state
  logic [8*KEY_CHARS-1:0] key_bits;
  logic [4:0]             key_len_q;
  logic [7:0]             open_q;
  logic [7:0]             close_q;
  logic                   keep_q;
  logic [7:0]             win_q [MAX_KEY_LEN_DEF];
  int                     fill_q;
  phase_t                 phase_q;

  field_word_t expected_words [$];
  int          mismatch_count;
  int          items_sent;
  int          idle_cycles;
  bit          send_gaps_on;
  bit          recv_gaps_on;
  bit          hold_off_req;

  keyed_field_extractor_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int key_span(input logic [4:0] len);
    int n;
    n = len;
    if (n == 0) n = 1;
    if (n > MAX_KEY_LEN_DEF) n = MAX_KEY_LEN_DEF;
    return n;
  endfunction

  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // advances the extractor copy by one byte; returns 1 when a word comes out
  function automatic bit extract_step(input logic [7:0] b, input logic eom,
                                      output field_word_t w);
    int  n;
    int  i;
    bit  hit;
    bit  has;
    has = 1'b0;
    w   = '{8'h00, 1'b0, ST_BYTE};
    for (i = MAX_KEY_LEN_DEF - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = b;
    if (fill_q < MAX_KEY_LEN_DEF) fill_q++;
    case (phase_q)
      PH_KEY: begin
        n   = key_span(key_len_q);
        hit = (fill_q >= n);
        for (i = 0; i < n; i++) begin
          if (win_q[n-1-i] != key_bits[8*i +: 8]) hit = 1'b0;
        end
        if (hit) phase_q = PH_OPEN;
      end
      PH_OPEN: begin
        if (b == open_q) phase_q = PH_FIELD;
      end
      PH_FIELD: begin
        if (b == close_q) begin
          w       = '{close_q, keep_q, ST_COMPLETE};
          has     = 1'b1;
          phase_q = PH_DONE;
        end else if (!eom) begin
          w   = '{b, 1'b1, ST_BYTE};
          has = 1'b1;
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (phase_q != PH_DONE) begin
        w   = '{8'h00, 1'b0, ST_NOT_FOUND};
        has = 1'b1;
      end
      for (i = 0; i < MAX_KEY_LEN_DEF; i++) win_q[i] = 8'h00;
      fill_q  = 0;
      phase_q = PH_KEY;
    end
    return has;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_KEY_LOW:  key_bits[63:0]   = v;
      CFG_KEY_HIGH: key_bits[127:64] = v;
      CFG_KEY_LEN:  key_len_q        = v[4:0];
      CFG_OPEN:     open_q           = v[7:0];
      CFG_CLOSE:    close_q          = v[7:0];
      CFG_KEEP:     keep_q           = v[0];
      default: ;
    endcase
  endtask

  task automatic set_key_text(input string s, input logic [4:0] len);
    logic [8*KEY_CHARS-1:0] k;
    int                     i;
    k = '0;
    for (i = 0; i < s.len() && i < KEY_CHARS; i++) k[8*i +: 8] = s[i];
    write_reg(CFG_KEY_LOW, k[63:0]);
    write_reg(CFG_KEY_HIGH, k[127:64]);
    write_reg(CFG_KEY_LEN, {59'd0, len});
  endtask

  task automatic set_delims(input logic [7:0] op, input logic [7:0] cl, input logic keep);
    write_reg(CFG_OPEN, {56'd0, op});
    write_reg(CFG_CLOSE, {56'd0, cl});
    write_reg(CFG_KEEP, {63'd0, keep});
  endtask

  // offers one word and waits for it to be taken; expectation is queued on acceptance
  task automatic send_word(input logic [7:0] b, input logic eom, input bit typed,
                           input bit typed_has, input field_word_t typed_w);
    int          gap;
    bit          has;
    field_word_t w;
    gap = pick_gap(send_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push           = 1'b1;
    in_byte           = b;
    in_end_of_message = eom;
    @(posedge clk);
    while (in_full) @(posedge clk);
    has = extract_step(b, eom, w);
    if (typed) begin
      has = typed_has;
      w   = typed_w;
    end
    if (has) expected_words.insert(expected_words.size(), w);
    items_sent++;
  endtask

  // one message: mostly key, opening byte, field, closing byte; some broken, some noise
  task automatic send_message(input int field_max);
    logic [7:0] msg [$];
    int         r;
    int         i;
    int         klen;
    klen = key_span(key_len_q);
    r    = $urandom_range(0, 99);
    repeat ($urandom_range(0, 3)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    if (r < 85) begin
      for (i = 0; i < klen; i++) msg.insert(msg.size(), key_bits[8*i +: 8]);
      repeat ($urandom_range(0, 2)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
      if (r < 78) begin
        msg.insert(msg.size(), open_q);
        repeat ($urandom_range(0, field_max))
          msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        if (r < 70) begin
          msg.insert(msg.size(), close_q);
          repeat ($urandom_range(0, 3)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    end
    if (msg.size() == 0) msg.insert(0, 8'($urandom_range(0, 255)));
    for (i = 0; i < msg.size(); i++) begin
      send_word(msg[i], i == msg.size() - 1, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic run_messages(input int quota, input bit pressure);
    int start;
    start = items_sent;
    if (pressure) begin
      hold_off_req = 1'b1;
      repeat (3) send_message(24);
    end
    while (items_sent - start < quota) send_message(8);
  endtask

  // block idle: input lowered, all words back, pipeline flushed
  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : pop_drive
    int gap;
    int k;
    out_pop = 1'b0;
    gap     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_pop = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (gap > 0) begin
        out_pop = 1'b0;
        gap--;
      end else begin
        out_pop = 1'b1;
        gap     = pick_gap(recv_gaps_on);
      end
    end
  end

  always @(posedge clk) begin : word_check
    field_word_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: byte %h valid %b status %0d",
                   out_byte, out_byte_valid, out_status);
      end else begin
        w = expected_words.pop_front();
        if (out_byte !== w.data || out_byte_valid !== w.valid || out_status !== w.st) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected byte %h valid %b status %0d, ",
                      "got byte %h valid %b status %0d"},
                     w.data, w.valid, w.st, out_byte, out_byte_valid, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    int len;
    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_byte           = 8'h00;
    in_end_of_message = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_KEY_LOW;
    cfg_data          = '0;
    mismatch_count    = 0;
    items_sent        = 0;
    idle_cycles       = 0;
    hold_off_req      = 1'b0;
    send_gaps_on      = 1'b1;
    recv_gaps_on      = 1'b1;
    key_bits          = '0;
    key_len_q         = 5'd1;
    open_q            = 8'd58;
    close_q           = 8'd44;
    keep_q            = 1'b0;
    for (i = 0; i < MAX_KEY_LEN_DEF; i++) win_q[i] = 8'h00;
    fill_q  = 0;
    phase_q = PH_KEY;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      send_word(DIR_TABLE[i].b, DIR_TABLE[i].eom, DIR_TABLE[i].typed,
                DIR_TABLE[i].has, DIR_TABLE[i].w);
    end
    settle();

    // fixed settings, extremes included
    set_key_text("price", 5'd5);
    set_delims(8'h3A, 8'h2C, 1'b1);
    recv_gaps_on = 1'b0;
    run_messages(60, 1'b0);
    settle();

    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LEN, 64'd16);
    set_delims(8'h00, 8'hFF, 1'b1);
    recv_gaps_on = 1'b1;
    run_messages(60, 1'b1);
    settle();

    // zero length acts as one
    set_key_text("", 5'd0);
    set_delims(8'hFF, 8'h00, 1'b0);
    run_messages(60, 1'b0);
    settle();

    // oversize length saturates; sixteenth key char is zero
    set_key_text("settlement_type", 5'd31);
    set_delims(8'h5B, 8'h5D, 1'b0);
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    run_messages(60, 1'b0);
    settle();

    // same byte opens and closes
    set_key_text("asks", 5'd4);
    set_delims(8'h5B, 8'h5B, 1'b1);
    send_gaps_on = 1'b1;
    run_messages(40, 1'b0);
    settle();

    while (items_sent < ITEM_TARGET) begin
      send_gaps_on = ($urandom_range(0, 3) != 0);
      recv_gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: set_key_text("amount", 5'd6);
        1: set_key_text("bids", 5'd4);
        default: begin
          len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31);
          write_reg(CFG_KEY_LOW, {$urandom, $urandom});
          write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
          write_reg(CFG_KEY_LEN, {$urandom, 27'($urandom), 5'(len)});
        end
      endcase
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_OPEN, {$urandom, $urandom});
        write_reg(CFG_CLOSE, {$urandom, $urandom});
        write_reg(CFG_KEEP, {$urandom, $urandom});
      end else begin
        case ($urandom_range(0, 2))
          0: set_delims(8'h3A, 8'h2C, 1'($urandom));
          1: set_delims(8'h5B, 8'h5D, 1'($urandom));
          default: set_delims(8'h3A, 8'h7D, 1'($urandom));
        endcase
      end
      run_messages((ITEM_TARGET - items_sent < 150) ? ITEM_TARGET - items_sent : 150,
                   $urandom_range(0, 1) != 0);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kfe_pkg.sv
sv/kfe_front.sv
sv/kfe_queue.sv
sv/kfe_back.sv
sv/keyed_field_extractor_top.sv
sv/kfe_checker.sv
dv/keyed_field_extractor_top_tb.sv
